// File: rtl/core/kvs_pkg.sv
// Shared types, constants and sequencer states of the keyframe vector sampler.
package kvs_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = KEY_AW + 1;
    localparam int DIV_W    = 48;   // |num| << 16
    localparam int DEN_W    = 32;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ACK    = 1'b1;

    localparam logic [2:0] REG_KEY_COUNT  = 3'd0;
    // byte address of a register is four times its index
    localparam logic [2:0] ADDR_KEY_COUNT = REG_KEY_COUNT << 2;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_key;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_CMP,
        ST_LD_CUR,
        ST_DIV,
        ST_DIFF,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

// File: rtl/core/kvs_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation weight.
module kvs_div
    import kvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [DEN_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DIV_W-1:0]   o_quotient
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_dvs;
    logic [DEN_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial = {r_rem, r_dvd[DIV_W-1]};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], qbit};
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_dvs}) : trial[DEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

// File: rtl/core/keyframe_vector_sampler.sv
// Keyframe table with forward cursor and fixed-point linear vector sampling.
//
// Usage: words come in on s_axis; tuser carries the request (write key, sample,
// reset cursor), tdata the slot, key time, key vector and query time. Every
// word gives exactly one result word on m_axis: a sample (tuser 0) with the
// Q16.16 vector and a saturation flag, or an acknowledgement (tuser 1) with
// zero data. key_count is set over the APB port at address 0; the user must
// write it only while idle, which the block does not enforce. The block
// takes one word at a time; s_axis_tready is high only when idle. Write,
// cursor reset and unused requests go straight to the output register.
// Sample: setup, then one table read and compare per key the cursor steps
// over, then the bit-serial weight divider (48 quotient bits), then the
// three components through one shared 32x32 multiplier (difference, low and
// high partial products, then the add and clip).
// No keys, one key, last key or equal times skip divider and multiplier.
// The result waits in an output register; a new word is taken while it is
// stalled, and the next result waits until the register is free.
// Reset clears cursor, key_count and handshake state; the table contents are
// undefined until written.
module keyframe_vector_sampler
    import kvs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // apb
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: key_slot[5:0], entry_time[37:6], entry_x[69:38], entry_y[101:70],
    //        entry_z[133:102], query_time[165:134], zero pad[167:166]
    input  logic [167:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]    s_axis_tuser,
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: out_x[31:0], out_y[63:32], out_z[95:64], saturated[96], zero[103:97]
    output logic [103:0]  m_axis_tdata,
    // tuser: out_kind[0]
    output logic [0:0]    m_axis_tuser
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_key_count;
    logic [KEY_AW-1:0]   r_cursor, n_cursor;
    logic [31:0]         r_q, n_q;
    logic                r_key_only, n_key_only;
    t_key                r_e0, n_e0, r_e1, n_e1;
    logic                r_wneg, n_wneg;
    logic [DIV_W-1:0]    r_w, n_w;
    logic [1:0]          r_comp, n_comp;
    logic [31:0]         r_dm, n_dm;
    logic                r_dneg, n_dneg;
    logic [63:0]         r_plo, n_plo;
    logic [47:0]         r_phi, n_phi;
    logic [31:0]         r_res [0:2];
    logic [31:0]         n_res [0:2];
    logic                r_sat, n_sat;
    logic                r_kind, n_kind;
    logic                r_m_valid;
    logic [31:0]         r_m_x, r_m_y, r_m_z;
    logic                r_m_sat, r_m_kind;

    t_key                r_mem [0:MAX_KEYS-1];
    t_key                r_rdata;
    logic [KEY_AW-1:0]   rd_addr;
    logic                mem_we;
    t_key                wr_key;

    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dvd, div_q;
    logic [DEN_W-1:0]    div_dvs;

    logic [CNT_W-1:0]    n_keys;
    logic [CNT_W-1:0]    c_next;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [32:0]         num, den, dif;
    logic [31:0]         v0, v1;
    logic [80:0]         full;
    logic signed [49:0]  acc, v0e, stepe;
    logic                out_free, cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_KEY_COUNT);
    assign prdata = (paddr == ADDR_KEY_COUNT) ? {25'd0, r_key_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_wr) begin
            r_key_count <= pwdata[CNT_W-1:0];
        end
    end

    assign n_keys = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;
    assign c_next = {1'b0, r_cursor} + CNT_W'(1);

    // key table
    assign wr_key = '{t: s_axis_tdata[37:6],   x: s_axis_tdata[69:38],
                      y: s_axis_tdata[101:70], z: s_axis_tdata[133:102]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[s_axis_tdata[KEY_AW-1:0]] <= wr_key;
        end
        r_rdata <= r_mem[rd_addr];
    end

    kvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // shared multiplier
    assign mul_b = (r_state == ST_MLO) ? r_w[31:0] : {16'd0, r_w[47:32]};
    assign mul_p = r_dm * mul_b;

    assign num = {1'b0, r_q} - {1'b0, r_rdata.t};
    assign den = {1'b0, r_e1.t} - {1'b0, r_rdata.t};
    assign div_dvd = {(num[32] ? 32'(-num) : num[31:0]), 16'd0};
    assign div_dvs = den[32] ? 32'(-den) : den[31:0];

    always_comb begin
        case (r_comp)
            2'd0:    begin v0 = r_e0.x; v1 = r_e1.x; end
            2'd1:    begin v0 = r_e0.y; v1 = r_e1.y; end
            default: begin v0 = r_e0.z; v1 = r_e1.z; end
        endcase
    end

    assign dif   = {v1[31], v1} - {v0[31], v0};
    assign full  = {1'b0, r_phi, 32'd0} + {17'd0, r_plo};
    assign v0e   = {{18{v0[31]}}, v0};
    assign stepe = {2'b00, full[63:16]};
    assign out_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_q        = r_q;
        n_key_only = r_key_only;
        n_e0       = r_e0;
        n_e1       = r_e1;
        n_wneg     = r_wneg;
        n_w        = r_w;
        n_comp     = r_comp;
        n_dm       = r_dm;
        n_dneg     = r_dneg;
        n_plo      = r_plo;
        n_phi      = r_phi;
        n_res      = r_res;
        n_sat      = r_sat;
        n_kind     = r_kind;
        rd_addr    = r_cursor;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        acc        = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_q      = s_axis_tdata[165:134];
                    n_res[0] = '0;
                    n_res[1] = '0;
                    n_res[2] = '0;
                    n_sat    = 1'b0;
                    n_kind   = KIND_ACK;
                    n_state  = ST_OUT;
                    case (s_axis_tuser)
                        REQ_WRITE:  mem_we = 1'b1;
                        REQ_SAMPLE: begin
                            n_kind  = KIND_SAMPLE;
                            n_state = ST_SETUP;
                        end
                        REQ_RESET:  n_cursor = '0;
                        default:    ;
                    endcase
                end
            end
            ST_SETUP: begin
                n_key_only = 1'b1;
                if (n_keys == '0) begin
                    n_state = ST_OUT;
                end else if (n_keys == CNT_W'(1)) begin
                    rd_addr = '0;
                    n_state = ST_LD_CUR;
                end else begin
                    if ({1'b0, r_cursor} >= n_keys) begin
                        n_cursor = KEY_AW'(n_keys - CNT_W'(1));
                    end
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (c_next < n_keys) begin
                    rd_addr = c_next[KEY_AW-1:0];
                    n_state = ST_CMP;
                end else begin
                    n_key_only = 1'b1;
                    n_state    = ST_LD_CUR;
                end
            end
            ST_CMP: begin
                if (r_rdata.t < r_q) begin
                    n_cursor = c_next[KEY_AW-1:0];
                    n_state  = ST_WALK;
                end else begin
                    n_e1       = r_rdata;
                    n_key_only = 1'b0;
                    n_state    = ST_LD_CUR;
                end
            end
            ST_LD_CUR: begin
                n_e0 = r_rdata;
                if (r_key_only || (r_rdata.t == r_e1.t)) begin
                    n_res[0] = r_rdata.x;
                    n_res[1] = r_rdata.y;
                    n_res[2] = r_rdata.z;
                    n_state  = ST_OUT;
                end else begin
                    n_wneg    = num[32] ^ den[32];
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_w     = div_q;
                    n_comp  = 2'd0;
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_dm    = dif[32] ? 32'(-dif) : dif[31:0];
                n_dneg  = dif[32];
                n_state = ST_MLO;
            end
            ST_MLO: begin
                n_plo   = mul_p;
                n_state = ST_MHI;
            end
            ST_MHI: begin
                n_phi   = mul_p[47:0];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                // product of 2^64 or more clips with the step's sign
                if (full[80:64] != '0) begin
                    acc = (r_wneg ^ r_dneg) ? -50'sd2147483649 : 50'sd2147483648;
                end else begin
                    acc = (r_wneg ^ r_dneg) ? v0e - stepe : v0e + stepe;
                end
                if (acc > 50'sd2147483647) begin
                    n_res[r_comp] = 32'h7FFF_FFFF;
                    n_sat         = 1'b1;
                end else if (acc < -50'sd2147483648) begin
                    n_res[r_comp] = 32'h8000_0000;
                    n_sat         = 1'b1;
                end else begin
                    n_res[r_comp] = acc[31:0];
                end
                n_comp  = r_comp + 2'd1;
                n_state = (r_comp == 2'd2) ? ST_OUT : ST_DIFF;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cursor  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_key_only <= n_key_only;
        r_e0       <= n_e0;
        r_e1       <= n_e1;
        r_wneg     <= n_wneg;
        r_w        <= n_w;
        r_comp     <= n_comp;
        r_dm       <= n_dm;
        r_dneg     <= n_dneg;
        r_plo      <= n_plo;
        r_phi      <= n_phi;
        r_res      <= n_res;
        r_sat      <= n_sat;
        r_kind     <= n_kind;
        if (r_state == ST_OUT && out_free) begin
            r_m_x    <= r_res[0];
            r_m_y    <= r_res[1];
            r_m_z    <= r_res[2];
            r_m_sat  <= r_sat;
            r_m_kind <= r_kind;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_sat, r_m_z, r_m_y, r_m_x};
    assign m_axis_tuser  = r_m_kind;

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == KIND_ACK) |-> (m_axis_tdata == '0))
        else $error("acknowledgement word carries data");

    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the weight step");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ({1'b0, r_cursor} < n_keys && n_keys >= CNT_W'(2)))
        else $error("cursor walk out of range");

    a_ld_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LD_CUR) |=> (r_state == ST_OUT || r_state == ST_DIV))
        else $error("bad step after key load");

endmodule
